// File: hdl/led_bar_pattern_sequencer_core_macros.svh
// Assertion macros for the LED bar pattern sequencer.
`ifndef LED_BAR_PATTERN_SEQUENCER_CORE_MACROS_SVH
`define LED_BAR_PATTERN_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold on every edge outside reset.
`define LBPS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset.
`define LBPS_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define LBPS_ASSERT(lbl, clk, rst, prop, msg)
`define LBPS_ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

// File: hdl/lbps_pkg.sv
package lbps_pkg;

   // Pattern select, low three bits of the ASCII code '0'..'7'
   typedef enum logic [2:0] {
      PAT_FIXED     = 3'd0,
      PAT_ALTERNATE = 3'd1,
      PAT_COUNT_UP  = 3'd2,
      PAT_BOUNCE    = 3'd3,
      PAT_COUNT_DN  = 3'd4,
      PAT_WALK_ONE  = 3'd5,
      PAT_WALK_ZERO = 3'd6,
      PAT_FILL      = 3'd7
   } pattern_type;

   // ASCII '0'..'7' share this upper part
   localparam logic [4:0] CODE_PREFIX = 5'b00110;

   localparam logic [7:0] FIXED_VALUE     = 8'hAA;
   localparam logic [7:0] ALT_RESTART     = 8'hAA;
   localparam logic [2:0] BOUNCE_LAST     = 3'd5;
   localparam logic [14:0] BASE_PERIOD_RST = 15'd16;

   typedef struct packed {
      logic [7:0] alternate_value;
      logic [7:0] up_count;
      logic [2:0] bounce_index;
      logic [7:0] down_count;
      logic [2:0] walk_one_index;
      logic [2:0] walk_zero_index;
      logic [2:0] fill_index;
   } lbps_state_type;

   localparam lbps_state_type STATE_RESET = '{
      alternate_value: 8'h55,
      up_count:        8'hFF,
      bounce_index:    3'd5,
      down_count:      8'h00,
      walk_one_index:  3'd7,
      walk_zero_index: 3'd7,
      fill_index:      3'd7
   };

   typedef struct packed {
      logic [7:0] led_value;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [2:0] speed_quarters;
   } lbps_step_type;

   function automatic logic [7:0] bounce_value(input logic [2:0] idx);
      logic [7:0] v;
      case (idx)
         3'd0:    v = 8'h18;
         3'd1:    v = 8'h24;
         3'd2:    v = 8'h42;
         3'd3:    v = 8'h81;
         3'd4:    v = 8'h42;
         3'd5:    v = 8'h24;
         default: v = 8'h18;
      endcase
      return v;
   endfunction

endpackage

// File: hdl/lbps_step.sv
module lbps_step
   import lbps_pkg::*;
(
   input  lbps_state_type state_cur,
   input  pattern_type    pattern,
   input  logic           restart,
   output lbps_state_type state_nxt,
   output lbps_step_type  result
);

   logic [2:0] idx_next;

   always_comb begin
      state_nxt = state_cur;
      result    = '0;
      idx_next  = 3'd0;
      unique case (pattern)
         PAT_FIXED: begin
            result.led_value      = FIXED_VALUE;
            result.red            = 8'hFF;
            result.green          = 8'hFF;
            result.blue           = 8'hFF;
            result.speed_quarters = 3'd4;
         end
         PAT_ALTERNATE: begin
            state_nxt.alternate_value = restart ? ALT_RESTART : ~state_cur.alternate_value;
            result.led_value      = state_nxt.alternate_value;
            result.red            = 8'h94;
            result.speed_quarters = 3'd4;
         end
         PAT_COUNT_UP: begin
            state_nxt.up_count    = restart ? 8'd0 : state_cur.up_count + 8'd1;
            result.led_value      = state_nxt.up_count;
            result.green          = 8'hFF;
            result.speed_quarters = 3'd2;
         end
         PAT_BOUNCE: begin
            // reset index is the last table entry, so the first step wraps to the start
            if (restart || state_cur.bounce_index >= BOUNCE_LAST) begin
               state_nxt.bounce_index = 3'd0;
            end else begin
               state_nxt.bounce_index = state_cur.bounce_index + 3'd1;
            end
            result.led_value      = bounce_value(state_nxt.bounce_index);
            result.red            = 8'hFF;
            result.green          = 8'h80;
            result.speed_quarters = 3'd2;
         end
         PAT_COUNT_DN: begin
            state_nxt.down_count  = restart ? 8'd0 : state_cur.down_count - 8'd1;
            result.led_value      = state_nxt.down_count;
            result.blue           = 8'hFF;
            result.speed_quarters = 3'd1;
         end
         PAT_WALK_ONE: begin
            idx_next = restart ? 3'd0 : state_cur.walk_one_index + 3'd1;
            state_nxt.walk_one_index = idx_next;
            result.led_value      = 8'h01 << idx_next;
            result.red            = 8'h15;
            result.green          = 8'h15;
            result.blue           = 8'h2E;
            result.speed_quarters = 3'd6;
         end
         PAT_WALK_ZERO: begin
            idx_next = restart ? 3'd0 : state_cur.walk_zero_index + 3'd1;
            state_nxt.walk_zero_index = idx_next;
            result.led_value      = ~(8'h80 >> idx_next);
            result.red            = 8'hFF;
            result.blue           = 8'hE1;
            result.speed_quarters = 3'd2;
         end
         PAT_FILL: begin
            idx_next = restart ? 3'd0 : state_cur.fill_index + 3'd1;
            state_nxt.fill_index  = idx_next;
            result.led_value      = 8'hFF >> (3'd7 - idx_next);
            result.red            = 8'h20;
            result.green          = 8'h46;
            result.blue           = 8'h22;
            result.speed_quarters = 3'd4;
         end
      endcase
   end

endmodule

// File: hdl/led_bar_pattern_sequencer_core.sv
// LED bar pattern sequencer core.
// req channel: one word per pattern step, req_pattern_code is the ASCII code
//   '0'..'7' of the pattern, req_restart puts that pattern back at its first
//   value. Any other code is consumed and produces no response.
// rsp channel: one word per valid step: LED bar value, RGB colour of the
//   pattern, and hold_ticks = (base_period * speed quarters) >> 2.
// csr channel: writes base_period; always ready. Write only while idle.
// Path: an accepted req word goes into the input register, then through the
//   pattern step into the result register, which drives rsp_valid.
//   Throughput: one word per cycle while rsp_ready is high, set by the single
//   step of pattern logic between the two registers.
// Stall: if rsp_ready is low, the result register holds and the input
//   register can still take one more word; req_ready drops only when both
//   are full.
// Reset: synchronous, active high; clears valids, restores base_period to 16
//   and every pattern position to its power-up value. No clearing pass.
`include "led_bar_pattern_sequencer_core_macros.svh"

module led_bar_pattern_sequencer_core
   import lbps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_pattern_code,
   input  logic        req_restart,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_led_value,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [15:0] rsp_hold_ticks,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [14:0] csr_base_period
);

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_code_ff;
   logic        in_restart_ff;

   // result register
   logic        rsp_valid_ff;
   logic [7:0]  rsp_led_ff;
   logic [7:0]  rsp_red_ff;
   logic [7:0]  rsp_green_ff;
   logic [7:0]  rsp_blue_ff;
   logic [15:0] rsp_hold_ff;

   logic [14:0]    base_period_ff;
   lbps_state_type state_ff;
   lbps_state_type state_in;
   lbps_step_type  step;

   logic        advance;     // input register moves into result register
   logic        code_ok;
   logic        commit;      // a valid step updates state and yields a word
   logic [17:0] hold_full;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign code_ok   = (in_code_ff[7:3] == CODE_PREFIX);
   assign commit    = advance && in_valid_ff && code_ok;

   lbps_step u_step (
      .state_cur (state_ff),
      .pattern   (pattern_type'(in_code_ff[2:0])),
      .restart   (in_restart_ff),
      .state_nxt (state_in),
      .result    (step)
   );

   // quarter-unit speed, truncated
   assign hold_full = 18'(base_period_ff) * 18'(step.speed_quarters);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         base_period_ff <= BASE_PERIOD_RST;
         state_ff       <= STATE_RESET;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff && code_ok;
         end
         if (commit) begin
            state_ff <= state_in;
         end
         if (csr_valid && csr_ready) begin
            base_period_ff <= csr_base_period;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_code_ff    <= req_pattern_code;
         in_restart_ff <= req_restart;
      end
      if (commit) begin
         rsp_led_ff   <= step.led_value;
         rsp_red_ff   <= step.red;
         rsp_green_ff <= step.green;
         rsp_blue_ff  <= step.blue;
         rsp_hold_ff  <= hold_full[17:2];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_led_value  = rsp_led_ff;
   assign rsp_red        = rsp_red_ff;
   assign rsp_green      = rsp_green_ff;
   assign rsp_blue       = rsp_blue_ff;
   assign rsp_hold_ticks = rsp_hold_ff;

   // checks
   `LBPS_ASSERT(a_hold_range, clock, reset, rsp_valid_ff |-> (rsp_hold_ff <= 16'd49150), "hold_ticks out of range")
   `LBPS_ASSERT(a_bad_code_drop, clock, reset, (advance && in_valid_ff && !code_ok) |=> !rsp_valid_ff, "unknown code produced a word")
   `LBPS_ASSERT_NEVER(a_no_overrun, clock, reset, in_valid_ff && rsp_valid_ff && !rsp_ready && req_ready, "req accepted with both registers full")

endmodule

// File: tb/led_bar_pattern_sequencer_core_test.sv
module led_bar_pattern_sequencer_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lbps_pkg::*;

   localparam int PHASES      = 8;
   localparam int PHASE_STEPS = 135;
   localparam int DRAIN_WAIT  = 4;    // pipe is two registers deep, a bit of margin
   localparam int END_WAIT    = 10;

   // one req word
   typedef struct packed {
      logic [7:0] code;
      logic       restart;
   } step_item_type;

   // one rsp word
   typedef struct packed {
      logic [7:0]  led;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] hold;
   } bar_word_type;

   localparam logic [7:0] BOUNCE_SEQ [6] = '{8'h18, 8'h24, 8'h42, 8'h81, 8'h42, 8'h24};

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_pattern_code;
   logic        req_restart;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_led_value;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [15:0] rsp_hold_ticks;
   logic        csr_valid;
   logic        csr_ready;
   logic [14:0] csr_base_period;

   led_bar_pattern_sequencer_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pattern_code (req_pattern_code),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_led_value    (rsp_led_value),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_hold_ticks   (rsp_hold_ticks),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_base_period  (csr_base_period)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow copy of the sequencer: base period plus one position per pattern.
   // ---------------------------------------------------------------------
   logic [14:0] sh_base_period = 15'd16;
   logic [7:0]  sh_alt_value   = 8'h55;
   logic [7:0]  sh_up_count    = 8'hFF;
   logic [2:0]  sh_bounce_idx  = 3'd5;
   logic [7:0]  sh_down_count  = 8'h00;
   logic [2:0]  sh_walk1_idx   = 3'd7;
   logic [2:0]  sh_walk0_idx   = 3'd7;
   logic [2:0]  sh_fill_idx    = 3'd7;

   bar_word_type  expected_words [$];
   step_item_type pending_steps  [$];

   int  error_count = 0;
   bit  idle_on     = 1'b1;   // random gaps on both channels
   bit  req_taken   = 1'b0;   // req word accepted at the last rising edge
   int  req_gap     = 0;
   int  rsp_stall   = 0;

   function automatic logic [7:0] code_of(input pattern_type p);
      return {CODE_PREFIX, p};
   endfunction

   // Advance the shadow positions for one step. Returns 0 for a code that
   // selects no pattern; those leave every position alone.
   function automatic bit advance_bar_pattern(input step_item_type s, output bar_word_type w);
      logic [2:0]  quarters;
      logic [17:0] product;
      pattern_type pat;
      if (s.code[7:3] != CODE_PREFIX) begin
         w = '0;
         return 1'b0;
      end
      pat = pattern_type'(s.code[2:0]);
      case (pat)
         PAT_FIXED: begin
            quarters = 3'd4;
            w.led = 8'hAA; w.red = 8'hFF; w.green = 8'hFF; w.blue = 8'hFF;
         end
         PAT_ALTERNATE: begin
            quarters = 3'd4;
            sh_alt_value = s.restart ? 8'hAA : ~sh_alt_value;
            w.led = sh_alt_value; w.red = 8'h94; w.green = 8'h00; w.blue = 8'h00;
         end
         PAT_COUNT_UP: begin
            quarters = 3'd2;
            sh_up_count = s.restart ? 8'h00 : sh_up_count + 8'd1;
            w.led = sh_up_count; w.red = 8'h00; w.green = 8'hFF; w.blue = 8'h00;
         end
         PAT_BOUNCE: begin
            quarters = 3'd2;
            // last table entry (also the power-up value) folds back to 0
            if (s.restart || sh_bounce_idx >= 3'd5)
               sh_bounce_idx = 3'd0;
            else
               sh_bounce_idx = sh_bounce_idx + 3'd1;
            w.led = BOUNCE_SEQ[sh_bounce_idx]; w.red = 8'hFF; w.green = 8'h80; w.blue = 8'h00;
         end
         PAT_COUNT_DN: begin
            quarters = 3'd1;
            sh_down_count = s.restart ? 8'h00 : sh_down_count - 8'd1;
            w.led = sh_down_count; w.red = 8'h00; w.green = 8'h00; w.blue = 8'hFF;
         end
         PAT_WALK_ONE: begin
            quarters = 3'd6;
            sh_walk1_idx = s.restart ? 3'd0 : sh_walk1_idx + 3'd1;
            w.led = 8'h01 << sh_walk1_idx; w.red = 8'h15; w.green = 8'h15; w.blue = 8'h2E;
         end
         PAT_WALK_ZERO: begin
            quarters = 3'd2;
            sh_walk0_idx = s.restart ? 3'd0 : sh_walk0_idx + 3'd1;
            w.led = ~(8'h80 >> sh_walk0_idx); w.red = 8'hFF; w.green = 8'h00; w.blue = 8'hE1;
         end
         default: begin   // PAT_FILL
            quarters = 3'd4;
            sh_fill_idx = s.restart ? 3'd0 : sh_fill_idx + 3'd1;
            w.led = 8'((9'd2 << sh_fill_idx) - 9'd1);
            w.red = 8'h20; w.green = 8'h46; w.blue = 8'h22;
         end
      endcase
      product = {3'b000, sh_base_period} * {15'd0, quarters};
      w.hold = product[17:2];
      return 1'b1;
   endfunction

   function automatic void compare_field(input string name, input logic [15:0] exp_v,
                                         input logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v, act_v);
         error_count++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: everything sampled at the rising edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      bar_word_type  exp_w;
      bar_word_type  pred_w;
      step_item_type s;
      req_taken = 1'b0;
      if (!reset) begin
         // response first: a word can't come out in the cycle its request went in
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected rsp word, expected none, actual led %0h hold %0h",
                        $realtime, rsp_led_value, rsp_hold_ticks);
               error_count++;
            end else begin
               exp_w = expected_words.pop_front();
               compare_field("led_value",  16'(exp_w.led),   16'(rsp_led_value));
               compare_field("red",        16'(exp_w.red),   16'(rsp_red));
               compare_field("green",      16'(exp_w.green), 16'(rsp_green));
               compare_field("blue",       16'(exp_w.blue),  16'(rsp_blue));
               compare_field("hold_ticks", exp_w.hold,       rsp_hold_ticks);
            end
         end
         if (csr_valid && csr_ready)
            sh_base_period = csr_base_period;
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            s.code    = req_pattern_code;
            s.restart = req_restart;
            if (advance_bar_pattern(s, pred_w))
               expected_words.push_back(pred_w);
         end
      end
   end

   // ---------------------------------------------------------------------
   // req driver: feeds pending_steps at the falling edge, random gaps.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      step_item_type s;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the word until it is taken
      end else if (req_gap > 0) begin
         req_gap--;
         req_valid <= 1'b0;
      end else if (pending_steps.size() > 0) begin
         if (idle_on && $urandom_range(0, 5) == 0) begin
            req_gap = $urandom_range(1, 8) - 1;
            req_valid <= 1'b0;
         end else begin
            s = pending_steps.pop_front();
            req_pattern_code <= s.code;
            req_restart      <= s.restart;
            req_valid        <= 1'b1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // rsp backpressure in bursts
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall = $urandom_range(1, 8) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic add_step(input logic [7:0] code, input logic restart);
      step_item_type s;
      s.code    = code;
      s.restart = restart;
      pending_steps.push_back(s);
   endtask

   // all words sent and answered; checked at the rising edge where the
   // driver's queue and req_valid agree
   task automatic wait_drained();
      while (pending_steps.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_base_period(input logic [14:0] value);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_base_period <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      logic [14:0] phase_base [PHASES];
      int          restart_div [PHASES];
      pattern_type pat;
      pattern_type prev_pat;
      logic [7:0]  code;
      logic        rst_bit;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_pattern_code = 8'h00;
      req_restart      = 1'b0;
      rsp_ready        = 1'b0;
      csr_valid        = 1'b0;
      csr_base_period  = 15'd0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part at the reset base period; power-up positions give
      // the wraps: count up 255->0, count down 0->255, bounce 5->0, walkers 7->0
      add_step(code_of(PAT_COUNT_UP), 1'b0);
      add_step(code_of(PAT_COUNT_UP), 1'b0);
      add_step(code_of(PAT_COUNT_UP), 1'b1);
      add_step(code_of(PAT_COUNT_DN), 1'b0);
      add_step(code_of(PAT_COUNT_DN), 1'b0);
      add_step(code_of(PAT_COUNT_DN), 1'b1);
      add_step(code_of(PAT_BOUNCE), 1'b0);
      add_step(code_of(PAT_BOUNCE), 1'b0);
      add_step(code_of(PAT_BOUNCE), 1'b1);
      add_step(code_of(PAT_ALTERNATE), 1'b0);
      add_step(code_of(PAT_ALTERNATE), 1'b0);
      add_step(code_of(PAT_ALTERNATE), 1'b1);
      add_step(code_of(PAT_FIXED), 1'b0);
      add_step(code_of(PAT_FIXED), 1'b1);       // restart means nothing here
      add_step(code_of(PAT_WALK_ONE), 1'b0);
      add_step(code_of(PAT_WALK_ONE), 1'b1);
      add_step(code_of(PAT_WALK_ZERO), 1'b0);
      add_step(code_of(PAT_WALK_ZERO), 1'b1);
      add_step(code_of(PAT_FILL), 1'b0);
      add_step(code_of(PAT_FILL), 1'b1);
      // codes outside '0'..'7': consumed, no word back, no state change
      add_step(8'h00, 1'b0);
      add_step(8'hFF, 1'b1);
      add_step(8'h2F, 1'b1);
      add_step(8'h38, 1'b0);
      add_step(8'hB5, 1'b1);
      wait_drained();

      phase_base[0] = 15'd0;                         restart_div[0] = 4;
      phase_base[1] = 15'h7FFF;                      restart_div[1] = 0;
      phase_base[2] = 15'd1;                         restart_div[2] = 16;
      phase_base[3] = 15'($urandom_range(0, 32767)); restart_div[3] = 8;
      phase_base[4] = 15'd3;                         restart_div[4] = 0;
      phase_base[5] = 15'h7FFE;                      restart_div[5] = 4;
      phase_base[6] = 15'($urandom_range(0, 32767)); restart_div[6] = 32;
      phase_base[7] = 15'd16;                        restart_div[7] = 8;

      prev_pat = PAT_FIXED;
      for (int ph = 0; ph < PHASES; ph++) begin
         // unknown codes may still be in flight: give the pipe time to empty
         repeat (DRAIN_WAIT) @(negedge clock);
         write_base_period(phase_base[ph]);
         if (ph == PHASES - 1)
            idle_on = 1'b0;   // last stretch runs at full rate
         for (int i = 0; i < PHASE_STEPS; i++) begin
            if ($urandom_range(0, 99) < 88) begin
               // mostly valid codes, often the same pattern again
               if ($urandom_range(0, 1) == 0)
                  pat = prev_pat;
               else
                  pat = pattern_type'($urandom_range(0, 7));
               prev_pat = pat;
               code = code_of(pat);
            end else begin
               code = 8'($urandom_range(0, 255));
            end
            rst_bit = (restart_div[ph] != 0) && ($urandom_range(0, restart_div[ph] - 1) == 0);
            add_step(code, rst_bit);
         end
         wait_drained();
      end

      repeat (END_WAIT) @(negedge clock);
      if (error_count == 0 && expected_words.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #(5_000_000);
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: files.f
+incdir+hdl
hdl/lbps_pkg.sv
hdl/lbps_step.sv
hdl/led_bar_pattern_sequencer_core.sv
tb/led_bar_pattern_sequencer_core_test.sv
